FILE: rtl/core/delimiter_field_splitter_assert.svh
// assertion macros shared by the splitter modules
`ifndef DELIMITER_FIELD_SPLITTER_ASSERT_SVH
`define DELIMITER_FIELD_SPLITTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DFS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define DFS_ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

`define DFS_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`else

`define DFS_ASSERT(label, clk, rstn, prop, msg)
`define DFS_ASSERT_IMPL(label, clk, rstn, cond, prop, msg)
`define DFS_ASSERT_NEXT(label, clk, rstn, cond, prop, msg)

`endif

`endif

FILE: rtl/core/dfs_pkg.sv
`timescale 1ns / 1ps

package dfs_pkg;

    localparam int MAX_DELIM = 8;
    localparam int MAX_LEN   = 65536;
    localparam int POS_W     = $clog2(MAX_LEN + 1);
    localparam int DIDX_W    = $clog2(MAX_DELIM);
    localparam int DLEN_W    = 4;
    localparam int CNT_W     = 17;
    localparam int LIM_W     = 17;
    localparam int OFS_W     = 16;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_EMPTY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELDS  = 3'd3;

    localparam logic [63:0]       RST_DELIM_BYTES = 64'd0;
    localparam logic [DLEN_W-1:0] RST_DELIM_LEN   = 4'd1;
    localparam logic              RST_KEEP_EMPTY  = 1'b0;
    localparam logic [LIM_W-1:0]  RST_MAX_FIELDS  = '1;

    typedef struct packed {
        logic [63:0]       delimiter_bytes;
        logic [DLEN_W-1:0] delimiter_length;
        logic              keep_empty;
        logic [LIM_W-1:0]  max_fields;
    } cfg_t;

    typedef struct packed {
        logic [MAX_DELIM-1:0][7:0] window;
        logic [POS_W-1:0]          pos;
        logic [POS_W-1:0]          cut;
        logic [CNT_W-1:0]          fields;
        logic                      limit_hit;
    } split_state_t;

    typedef struct packed {
        logic [OFS_W-1:0] field_start;
        logic [OFS_W-1:0] field_length;
        logic [CNT_W-1:0] field_number;
        logic             final_field;
        logic             last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_out_t;

    function automatic logic [OFS_W-1:0] clip16(input logic [POS_W-1:0] v);
        logic [POS_W+OFS_W-1:0] wide;
        wide = (POS_W + OFS_W)'(v);
        return (wide > (POS_W + OFS_W)'({OFS_W{1'b1}})) ? {OFS_W{1'b1}} : OFS_W'(v);
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] n);
        return (n == {CNT_W{1'b1}}) ? n : n + 1'b1;
    endfunction

endpackage

FILE: rtl/core/dfs_step.sv
`timescale 1ns / 1ps

module dfs_step (
    input  dfs_pkg::cfg_t         cfg,
    input  dfs_pkg::split_state_t cur,
    input  logic [7:0]            byte_value,
    input  logic                  last_byte,
    output dfs_pkg::split_state_t nxt,
    output dfs_pkg::step_out_t    out
);

    logic [dfs_pkg::DLEN_W-1:0]           len_eff;
    logic [dfs_pkg::DIDX_W-1:0]           len_idx;
    logic [dfs_pkg::MAX_DELIM-1:0][7:0]   win_new;
    logic [dfs_pkg::MAX_DELIM-1:0]        match_vec;
    logic                                 match;
    logic                                 lim_pos;
    logic                                 lim_neg;
    logic [dfs_pkg::OFS_W-1:0]            lim_mag;
    logic [dfs_pkg::POS_W-1:0]            pos_new;
    logic [dfs_pkg::POS_W-1:0]            span;
    logic [dfs_pkg::POS_W-1:0]            flen;
    logic [dfs_pkg::POS_W-1:0]            cut;
    logic [dfs_pkg::CNT_W-1:0]            fe_a;
    logic                                 lh;
    logic                                 emit_a;
    logic                                 emit_b;
    logic [dfs_pkg::POS_W-1:0]            start_b;
    logic [dfs_pkg::POS_W-1:0]            len_b;
    dfs_pkg::result_t                     res_a;
    dfs_pkg::result_t                     res_b;

    always_comb begin
        if (cfg.delimiter_length == '0) begin
            len_eff = dfs_pkg::DLEN_W'(1);
        end else if (cfg.delimiter_length > dfs_pkg::DLEN_W'(dfs_pkg::MAX_DELIM)) begin
            len_eff = dfs_pkg::DLEN_W'(dfs_pkg::MAX_DELIM);
        end else begin
            len_eff = cfg.delimiter_length;
        end
        len_idx = dfs_pkg::DIDX_W'(len_eff - 1'b1);

        win_new[0] = byte_value;
        for (int i = 1; i < dfs_pkg::MAX_DELIM; i++) begin
            win_new[i] = cur.window[i-1];
        end

        // one compare per possible delimiter length, window newest first
        for (int l = 0; l < dfs_pkg::MAX_DELIM; l++) begin
            match_vec[l] = 1'b1;
            for (int k = 0; k < dfs_pkg::MAX_DELIM; k++) begin
                if (k <= l) begin
                    if (win_new[l-k] != cfg.delimiter_bytes[8*k +: 8]) begin
                        match_vec[l] = 1'b0;
                    end
                end
            end
        end
        match = match_vec[len_idx];

        lim_neg = cfg.max_fields[dfs_pkg::LIM_W-1];
        lim_mag = cfg.max_fields[dfs_pkg::OFS_W-1:0];
        lim_pos = !lim_neg && (lim_mag != '0);

        pos_new = (cur.pos == dfs_pkg::POS_MAX) ? cur.pos : cur.pos + 1'b1;
        span    = pos_new - cur.cut;
        flen    = span - dfs_pkg::POS_W'(len_eff);

        fe_a   = cur.fields;
        lh     = cur.limit_hit;
        cut    = cur.cut;
        emit_a = 1'b0;
        if (!cur.limit_hit && (span >= dfs_pkg::POS_W'(len_eff)) && match) begin
            if ((flen != '0) || cfg.keep_empty) begin
                if (lim_pos && ((dfs_pkg::CNT_W + 1)'(cur.fields) + 1'b1
                                >= (dfs_pkg::CNT_W + 1)'(lim_mag))) begin
                    lh = 1'b1;
                end else begin
                    fe_a   = dfs_pkg::bump(cur.fields);
                    emit_a = 1'b1;
                end
            end
            if (!lh) begin
                cut = pos_new;
            end
        end

        // tail field on the final byte
        emit_b  = 1'b0;
        start_b = cut;
        len_b   = pos_new - cut;
        if (last_byte) begin
            if (lh || (cut < pos_new)) begin
                emit_b = 1'b1;
            end else if (cfg.keep_empty && (lim_neg || ((dfs_pkg::CNT_W + 1)'(fe_a)
                                            < (dfs_pkg::CNT_W + 1)'(lim_mag)))) begin
                emit_b  = 1'b1;
                start_b = pos_new;
                len_b   = '0;
            end
        end

        res_a.field_start  = dfs_pkg::clip16(cur.cut);
        res_a.field_length = dfs_pkg::clip16(flen);
        res_a.field_number = fe_a;
        res_a.final_field  = last_byte && !emit_b;
        res_a.last_of_run  = !emit_b;

        res_b.field_start  = dfs_pkg::clip16(start_b);
        res_b.field_length = dfs_pkg::clip16(len_b);
        res_b.field_number = dfs_pkg::bump(fe_a);
        res_b.final_field  = 1'b1;
        res_b.last_of_run  = 1'b1;

        out.res1 = res_b;
        if (emit_a) begin
            out.res0  = res_a;
            out.count = emit_b ? 2'd2 : 2'd1;
        end else begin
            out.res0  = res_b;
            out.count = emit_b ? 2'd1 : 2'd0;
        end

        if (last_byte) begin
            nxt = '0;
        end else begin
            nxt.window    = win_new;
            nxt.pos       = pos_new;
            nxt.cut       = cut;
            nxt.fields    = fe_a;
            nxt.limit_hit = lh;
        end
    end

endmodule

FILE: rtl/core/dfs_fifo.sv
`timescale 1ns / 1ps
`include "delimiter_field_splitter_assert.svh"

module dfs_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  dfs_pkg::step_out_t push,
    input  logic               pop_ready,
    output dfs_pkg::result_t   head,
    output logic               head_valid,
    output logic               room
);

    dfs_pkg::result_t                 mem_reg [dfs_pkg::FIFO_DEPTH];
    logic [dfs_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [dfs_pkg::FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [dfs_pkg::FIFO_PTR_W-1:0]   wr_ptr_inc;
    logic [dfs_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [dfs_pkg::FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [dfs_pkg::FIFO_CNT_W-1:0]   cnt_reg;
    logic [dfs_pkg::FIFO_CNT_W-1:0]   cnt_next;
    logic                             pop;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != '0);
    // space for the two beats a single byte can produce
    assign room       = (cnt_reg <= dfs_pkg::FIFO_CNT_W'(dfs_pkg::FIFO_DEPTH - 2));
    assign pop        = head_valid && pop_ready;

    always_comb begin
        wr_ptr_inc  = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + dfs_pkg::FIFO_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + dfs_pkg::FIFO_CNT_W'(push.count)
                      - dfs_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push.res1;
        end
    end

    `DFS_ASSERT(a_fifo_bound, aclk, aresetn, cnt_reg <= dfs_pkg::FIFO_CNT_W'(dfs_pkg::FIFO_DEPTH), "result queue over depth")
    `DFS_ASSERT_IMPL(a_fifo_push_fits, aclk, aresetn, push.count != 2'd0, ({1'b0, cnt_reg} + {2'b0, push.count}) <= (dfs_pkg::FIFO_CNT_W + 1)'(dfs_pkg::FIFO_DEPTH), "push overflows result queue")
    `DFS_ASSERT_NEXT(a_fifo_pop_only, aclk, aresetn, pop && (push.count == 2'd0), cnt_reg == $past(cnt_reg) - 1'b1, "pop did not drain one beat")

endmodule

FILE: rtl/core/delimiter_field_splitter.sv
`timescale 1ns / 1ps
`include "delimiter_field_splitter_assert.svh"

// Splits a byte stream on a configured delimiter of 1 to 8 bytes and reports each
// field as start offset, length and one-based number. One byte is taken per cycle:
// the input beat is registered, the window compare and counter update run in one
// pass into a four-entry result queue, so a field reaches m_ through the input
// register and that queue. Each byte yields at most one result, except the
// final byte of a string, which may close a delimited field and the tail field,
// giving two result beats; the input keeps flowing as long as the queue
// has room for two beats. Configuration writes are taken at any time on cfg_ and
// must only be issued while no beat is in flight and no results are pending.
module delimiter_field_splitter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_byte_value,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dfs_pkg::OFS_W-1:0]       m_field_start,
    output logic [dfs_pkg::OFS_W-1:0]       m_field_length,
    output logic [dfs_pkg::CNT_W-1:0]       m_field_number,
    output logic                            m_final_field,
    output logic                            m_last_of_run,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                     cfg_data
);

    dfs_pkg::cfg_t          cfg_reg;
    dfs_pkg::split_state_t  state_reg;
    dfs_pkg::split_state_t  state_next;
    dfs_pkg::step_out_t     step_out;
    dfs_pkg::step_out_t     push_beat;
    dfs_pkg::result_t       head;
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   room;
    logic                   advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && room;
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delimiter_bytes  <= dfs_pkg::RST_DELIM_BYTES;
            cfg_reg.delimiter_length <= dfs_pkg::RST_DELIM_LEN;
            cfg_reg.keep_empty       <= dfs_pkg::RST_KEEP_EMPTY;
            cfg_reg.max_fields       <= dfs_pkg::RST_MAX_FIELDS;
        end else if (cfg_valid) begin
            case (cfg_index)
                dfs_pkg::REG_DELIM_BYTES: begin
                    cfg_reg.delimiter_bytes <= cfg_data;
                end
                dfs_pkg::REG_DELIM_LEN: begin
                    cfg_reg.delimiter_length <= cfg_data[dfs_pkg::DLEN_W-1:0];
                end
                dfs_pkg::REG_KEEP_EMPTY: begin
                    cfg_reg.keep_empty <= cfg_data[0];
                end
                dfs_pkg::REG_MAX_FIELDS: begin
                    cfg_reg.max_fields <= cfg_data[dfs_pkg::LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_value;
            in_last_reg <= s_last_byte;
        end
    end

    dfs_step u_step (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .byte_value (in_byte_reg),
        .last_byte  (in_last_reg),
        .nxt        (state_next),
        .out        (step_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        push_beat = step_out;
        if (!advance) begin
            push_beat.count = 2'd0;
        end
    end

    dfs_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_beat),
        .pop_ready  (m_ready),
        .head       (head),
        .head_valid (m_valid),
        .room       (room)
    );

    assign m_field_start  = head.field_start;
    assign m_field_length = head.field_length;
    assign m_field_number = head.field_number;
    assign m_final_field  = head.final_field;
    assign m_last_of_run  = head.last_of_run;

    `DFS_ASSERT(a_cut_behind_pos, aclk, aresetn, state_reg.cut <= state_reg.pos,
        "cut ahead of byte position")
    `DFS_ASSERT_NEXT(a_string_clears, aclk, aresetn, advance && in_last_reg,
        state_reg.pos == '0, "string state not cleared after final byte")
    `DFS_ASSERT_IMPL(a_two_only_final, aclk, aresetn, advance && (step_out.count == 2'd2),
        in_last_reg, "two results from a non-final byte")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dfs_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    // index past the last register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    class field_scoreboard;
        // configuration copy
        logic [63:0]        dbytes;
        logic [DLEN_W-1:0]  dlen;
        logic               keep;
        logic signed [16:0] maxf;
        // string state
        logic [7:0]         win [MAX_DELIM];
        int unsigned        pos;
        int unsigned        cut;
        logic [CNT_W-1:0]   nfields;
        bit                 lim_hit;
        result_t            pending_fields [$];
        int                 errors;

        function new();
            dbytes = RST_DELIM_BYTES;
            dlen   = RST_DELIM_LEN;
            keep   = RST_KEEP_EMPTY;
            maxf   = RST_MAX_FIELDS;
            errors = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (win[i]) win[i] = 8'h00;
            pos     = 0;
            cut     = 0;
            nfields = '0;
            lim_hit = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                REG_DELIM_BYTES: dbytes = data;
                REG_DELIM_LEN:   dlen = data[DLEN_W-1:0];
                REG_KEEP_EMPTY:  keep = data[0];
                REG_MAX_FIELDS:  maxf = data[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned delim_len();
            if (dlen == 0) return 1;
            if (dlen > MAX_DELIM) return MAX_DELIM;
            return dlen;
        endfunction

        function logic [7:0] delim_byte(int unsigned k);
            return dbytes[8*k +: 8];
        endfunction

        function result_t make_field(int unsigned start, int unsigned len);
            result_t r;
            nfields = (nfields == {CNT_W{1'b1}}) ? nfields : nfields + 1'b1;
            r.field_start  = (start > 65535) ? 16'hFFFF : start[15:0];
            r.field_length = (len > 65535) ? 16'hFFFF : len[15:0];
            r.field_number = nfields;
            r.final_field  = 1'b0;
            r.last_of_run  = 1'b0;
            return r;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int unsigned len;
            int unsigned fend;
            int unsigned flen;
            int          lim;
            bit          hit;
            result_t     outs [$];
            len = delim_len();
            lim = maxf;
            for (int i = MAX_DELIM - 1; i > 0; i--) win[i] = win[i-1];
            win[0] = b;
            if (pos < MAX_LEN) pos++;
            fend = pos;

            if (!lim_hit && fend - cut >= len) begin
                hit = 1;
                for (int k = 0; k < len; k++) begin
                    if (win[len-1-k] != delim_byte(k)) hit = 0;
                end
                if (hit) begin
                    flen = fend - len - cut;
                    if (flen > 0 || keep) begin
                        if (lim > 0 && int'(nfields) + 1 >= lim) begin
                            lim_hit = 1;
                        end else begin
                            outs.push_back(make_field(cut, flen));
                        end
                    end
                    if (!lim_hit) cut = fend;
                end
            end

            if (last) begin
                if (lim_hit || cut < fend) begin
                    outs.push_back(make_field(cut, fend - cut));
                end else if (keep && (lim < 0 || int'(nfields) < lim)) begin
                    outs.push_back(make_field(fend, 0));
                end
                if (outs.size() > 0) outs[outs.size()-1].final_field = 1'b1;
                clear_string();
            end

            if (outs.size() > 0) outs[outs.size()-1].last_of_run = 1'b1;
            foreach (outs[i]) pending_fields.push_back(outs[i]);
        endfunction

        function void compare(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_field(result_t got);
            result_t want;
            if (pending_fields.size() == 0) begin
                errors++;
                $display("%0t: unexpected field beat, expected none actual %p",
                         $time, got);
                return;
            end
            want = pending_fields.pop_front();
            compare("field_start", want.field_start, got.field_start);
            compare("field_length", want.field_length, got.field_length);
            compare("field_number", want.field_number, got.field_number);
            compare("final_field", want.final_field, got.final_field);
            compare("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

        function int pending();
            return pending_fields.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_byte_value = 8'h00;
    logic                  s_last_byte = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OFS_W-1:0]      m_field_start;
    logic [OFS_W-1:0]      m_field_length;
    logic [CNT_W-1:0]      m_field_number;
    logic                  m_final_field;
    logic                  m_last_of_run;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [63:0]           cfg_data = '0;

    field_scoreboard sb = new();
    bit  tx_idle = 1;
    bit  rx_idle = 1;
    bit  hold_armed = 0;
    bit  hold_done = 0;
    int  hold_left = 0;
    int  bytes_sent = 0;
    int  cycles = 0;
    cfg_t plan [7];

    delimiter_field_splitter DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_value   (s_byte_value),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_field_start  (m_field_start),
        .m_field_length (m_field_length),
        .m_field_number (m_field_number),
        .m_final_field  (m_final_field),
        .m_last_of_run  (m_last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // field receiver with random stalls and one long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_field({m_field_start, m_field_length, m_field_number,
                            m_final_field, m_last_of_run});
        end
        if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(rx_idle && $urandom_range(99) < 17);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (tx_idle && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_byte_value <= b;
        s_last_byte  <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_string(input logic [7:0] bytes [$]);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // leaves cfg_valid high, the caller lowers it after the last beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic set_config(input cfg_t c);
        write_reg(REG_DELIM_BYTES, c.delimiter_bytes);
        write_reg(REG_DELIM_LEN, 64'(c.delimiter_length));
        write_reg(REG_KEEP_EMPTY, 64'(c.keep_empty));
        write_reg(REG_MAX_FIELDS, 64'(c.max_fields));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // mostly well-formed fields and delimiters, some partial delimiters and noise
    task automatic send_random_string();
        logic [7:0]  q [$];
        int unsigned len;
        int          r;
        int          n;
        len = sb.delim_len();
        repeat ($urandom_range(1, 6)) begin
            r = $urandom_range(99);
            if (r < 45) begin
                repeat ($urandom_range(0, 4)) begin
                    if ($urandom_range(9) < 6)
                        q.push_back(sb.delim_byte($urandom_range(len - 1)));
                    else
                        q.push_back(8'($urandom_range(255)));
                end
            end else if (r < 85) begin
                for (int j = 0; j < len; j++) q.push_back(sb.delim_byte(j));
            end else if (r < 93) begin
                n = $urandom_range(0, len - 1);
                for (int j = 0; j < n; j++) q.push_back(sb.delim_byte(j));
            end else begin
                q.push_back(8'($urandom_range(255)));
            end
        end
        if (q.size() == 0) q.push_back(8'($urandom_range(255)));
        send_string(q);
    endtask

    initial begin
        int start;
        plan[0] = '{64'h2C, 4'd1, 1'b0, 17'h1FFFF};
        plan[1] = '{64'h3B2C, 4'd2, 1'b1, 17'd3};
        plan[2] = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 17'd0};
        plan[3] = '{{$urandom, $urandom}, 4'd15, 1'b0, 17'd65535};
        plan[4] = '{{$urandom, $urandom}, 4'd0, 1'b1, 17'd2};
        plan[5] = '{64'h616161, 4'd3, 1'b1, 17'h10000};
        plan[6] = '{64'h0, 4'd5, 1'b0, 17'd1};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero byte delimiter, empties skipped, no tail on the last string
        send_string('{8'hFF, 8'h00, 8'h80});
        send_string('{8'h00, 8'h00});
        drain();

        // zero length reads as one; a lone delimiter gives two empty fields on one beat
        set_config('{64'h2C, 4'd0, 1'b1, 17'h1FFFF});
        send_string('{8'h2C});
        send_string('{8'h2C, 8'h61, 8'h2C});
        drain();

        // repeated byte delimiter: leftmost, no overlap; junk in unused bytes
        set_config('{64'hDEAD_BEEF_0BAD_6161, 4'd2, 1'b1, 17'h10000});
        send_string('{8'h61, 8'h61, 8'h61, 8'h61, 8'h61});
        drain();

        // length above eight saturates; zero limit drops the trailing empty field
        set_config('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 17'd0});
        send_string('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        drain();

        // limit of two: remainder with its delimiter becomes the last field
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        set_config('{64'h2C, 4'd1, 1'b0, 17'd2});
        send_string('{8'h61, 8'h2C, 8'h62, 8'h2C, 8'h63});
        drain();

        for (int p = 0; p < 7; p++) begin
            set_config(plan[p]);
            tx_idle = !(p == 2 || p == 3);
            rx_idle = tx_idle;
            if (p == 0) hold_armed = 1;
            start = bytes_sent;
            while (bytes_sent - start < 300) send_random_string();
            drain();
        end

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
